FILE: rtl/core/chse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chse_pkg
// Shared sizes, codes and bus types for the chained hash set engine.
// ----------------------------------------------------------------------------
package chse_pkg;

    // Table geometry
    localparam int ENTRIES  = 64;
    localparam int NBUCKETS = 2 * ENTRIES;
    localparam int SLOT_W   = $clog2(ENTRIES);
    localparam int LINK_W   = $clog2(ENTRIES + 1);
    localparam int BKT_W    = $clog2(NBUCKETS);
    localparam int KEY_W    = 31;
    localparam int HASH_W   = 32;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(ENTRIES);

    // Hash sequencer: last step index
    localparam logic [2:0] MIX_LAST = 3'd5;

    typedef enum logic [1:0] {
        CMD_FIND           = 2'd0,
        CMD_INSERT         = 2'd1,
        CMD_FIND_OR_INSERT = 2'd2,
        CMD_ERASE          = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_FOUND    = 3'd0,
        ST_NOTFOUND = 3'd1,
        ST_INSERTED = 3'd2,
        ST_PRESENT  = 3'd3,
        ST_FULL     = 3'd4,
        ST_ERASED   = 3'd5
    } status_t;

    // Write requests from the sequencer to the table store
    typedef struct packed {
        logic              head_we;
        logic [BKT_W-1:0]  head_waddr;
        logic [LINK_W-1:0] head_wdata;
        logic [SLOT_W-1:0] slot_waddr;
        logic              link_we;
        logic [LINK_W-1:0] link_wdata;
        logic              key_we;
        logic [KEY_W-1:0]  key_wdata;
        logic              live_we;
        logic              live_wdata;
    } chse_wr_t;

    // Registered read data from the table store
    typedef struct packed {
        logic [LINK_W-1:0] head;
        logic [KEY_W-1:0]  key;
        logic [LINK_W-1:0] link;
        logic              live;
    } chse_rd_t;

endpackage

FILE: rtl/core/chse_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/chse_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chse_mixer
// Iterative 32-bit key mixer: one shift/add/xor step per cycle, six steps.
// ----------------------------------------------------------------------------
module chse_mixer
    import chse_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [KEY_W-1:0] key,
    output logic             done,
    output logic [BKT_W-1:0] bucket
);

    logic [HASH_W-1:0] k_reg;
    logic [HASH_W-1:0] k_next;
    logic [2:0]        step_reg;
    logic              run_reg;
    logic              done_reg;

    // One mixing step picked by the step counter
    function automatic logic [HASH_W-1:0] mix_step(input logic [HASH_W-1:0] k,
                                                   input logic [2:0] s);
        logic [HASH_W-1:0] r;
        case (s)
            3'd0:    r = (~k) + (k << 15);
            3'd1:    r = k ^ (k >> 12);
            3'd2:    r = k + (k << 2);
            3'd3:    r = k ^ (k >> 4);
            3'd4:    r = k + (k << 3) + (k << 11);
            3'd5:    r = k ^ (k >> 16);
            default: r = k;
        endcase
        return r;
    endfunction

    assign k_next = mix_step(k_reg, step_reg);

    // Load the key, then advance one step per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == MIX_LAST)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Hash word: payload only
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            k_reg <= {1'b0, key};
        end
        else if (run_reg)
        begin
            k_reg <= k_next;
        end
    end

    assign done   = done_reg;
    assign bucket = k_reg[BKT_W-1:0] & BKT_W'(NBUCKETS - 1);

endmodule

FILE: rtl/core/chse_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chse_store
// Bucket heads, slot keys and slot links in RAM, with flop valid bits that
// supply the reset contents until an entry is first written.
// ----------------------------------------------------------------------------
module chse_store
    import chse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [BKT_W-1:0]  head_raddr,
    input  logic [SLOT_W-1:0] slot_raddr,
    input  chse_wr_t          wr,
    output chse_rd_t          rd
);

    logic [NBUCKETS-1:0] head_vld_reg;
    logic [ENTRIES-1:0]  link_vld_reg;
    logic [ENTRIES-1:0]  live_reg;
    logic                head_vld_q_reg;
    logic                link_vld_q_reg;
    logic                live_q_reg;
    logic [SLOT_W-1:0]   slot_addr_q_reg;
    logic [LINK_W-1:0]   head_ram_q;
    logic [LINK_W-1:0]   link_ram_q;
    logic [KEY_W-1:0]    key_ram_q;

    chse_ram #(.WIDTH(LINK_W), .DEPTH(NBUCKETS)) u_head_ram (
        .clk   (clk),
        .we    (wr.head_we),
        .waddr (wr.head_waddr),
        .wdata (wr.head_wdata),
        .raddr (head_raddr),
        .rdata (head_ram_q)
    );

    chse_ram #(.WIDTH(LINK_W), .DEPTH(ENTRIES)) u_link_ram (
        .clk   (clk),
        .we    (wr.link_we),
        .waddr (wr.slot_waddr),
        .wdata (wr.link_wdata),
        .raddr (slot_raddr),
        .rdata (link_ram_q)
    );

    chse_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .clk   (clk),
        .we    (wr.key_we),
        .waddr (wr.slot_waddr),
        .wdata (wr.key_wdata),
        .raddr (slot_raddr),
        .rdata (key_ram_q)
    );

    // Track written entries and live slots; sample them with each read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld_reg   <= '0;
            link_vld_reg   <= '0;
            live_reg       <= '0;
            head_vld_q_reg <= 1'b0;
            link_vld_q_reg <= 1'b0;
            live_q_reg     <= 1'b0;
        end
        else
        begin
            if (wr.head_we)
            begin
                head_vld_reg[wr.head_waddr] <= 1'b1;
            end
            if (wr.link_we)
            begin
                link_vld_reg[wr.slot_waddr] <= 1'b1;
            end
            if (wr.live_we)
            begin
                live_reg[wr.slot_waddr] <= wr.live_wdata;
            end
            head_vld_q_reg <= head_vld_reg[head_raddr];
            link_vld_q_reg <= link_vld_reg[slot_raddr];
            live_q_reg     <= live_reg[slot_raddr];
        end
    end

    // Hold the slot address for the reset link value
    always_ff @(posedge clk)
    begin
        slot_addr_q_reg <= slot_raddr;
    end

    // Unwritten heads read as null, unwritten links as the next slot
    assign rd.head = head_vld_q_reg ? head_ram_q : NIL;
    assign rd.link = link_vld_q_reg ? link_ram_q
                                    : LINK_W'(slot_addr_q_reg) + LINK_W'(1);
    assign rd.key  = key_ram_q;
    assign rd.live = live_q_reg;

endmodule

FILE: rtl/core/chained_hash_set_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_set_engine_unit
// Fixed-capacity set of 31-bit keys in hashed buckets with linked chains.
//
//   Channel   Handshake         Beat contents
//   -------   ---------------   -----------------------------------
//   command   start / busy      command, key
//   result    done (strobe)     status, slot_index, occupancy
//
// A command runs the six-step hash unit, then walks the bucket chain, one
// entry per read of the one-read-per-cycle slot RAM port; inserts and erases
// end with table write states. An insert into a full table answers once the
// hash is done. busy stays high from the accepted beat until the cycle its
// result shows on done. Reset clears the tables at once through valid bits;
// no clearing pass. done lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module chained_hash_set_engine_unit
    import chse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        command,
    input  logic [KEY_W-1:0]  key,
    output logic              busy,
    output logic              done,
    output logic [2:0]        status,
    output logic [SLOT_W-1:0] slot_index,
    output logic [LINK_W-1:0] occupancy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_HEAD,
        S_SLOT,
        S_ALLOC_WR,
        S_ALLOC_FIN,
        S_ERASE_UNLINK,
        S_ERASE_FREE
    } state_t;

    state_t            state_reg,     state_next;
    cmd_t              cmd_reg,       cmd_next;
    logic [KEY_W-1:0]  key_reg,       key_next;
    logic [BKT_W-1:0]  bkt_reg,       bkt_next;
    logic [SLOT_W-1:0] cur_reg,       cur_next;
    logic [LINK_W-1:0] prev_reg,      prev_next;
    logic [LINK_W-1:0] tail_reg,      tail_next;
    logic [LINK_W-1:0] step_reg,      step_next;
    logic [LINK_W-1:0] hit_link_reg,  hit_link_next;
    logic [LINK_W-1:0] free_head_reg, free_head_next;
    logic [LINK_W-1:0] count_reg,     count_next;
    logic              done_reg,      done_next;
    status_t           status_reg,    status_next;
    logic [SLOT_W-1:0] slot_reg,      slot_next;
    logic [LINK_W-1:0] occ_reg,       occ_next;

    logic              mix_start;
    logic              mix_done;
    logic [BKT_W-1:0]  mix_bucket;
    logic [BKT_W-1:0]  head_raddr;
    logic [SLOT_W-1:0] slot_raddr;
    chse_wr_t          wr;
    chse_rd_t          rd;

    logic              full;
    logic              head_empty;
    logic              slot_hit;
    logic              chain_end;
    logic              walk_miss;
    logic [LINK_W-1:0] tail_v;
    logic              fin;
    status_t           fin_status;
    logic [SLOT_W-1:0] fin_slot;

    chse_mixer u_mixer (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mix_start),
        .key    (key_next),
        .done   (mix_done),
        .bucket (mix_bucket)
    );

    chse_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_raddr (head_raddr),
        .slot_raddr (slot_raddr),
        .wr         (wr),
        .rd         (rd)
    );

    // Chain walk conditions
    assign full       = (free_head_reg >= NIL);
    assign head_empty = (rd.head >= NIL);
    assign slot_hit   = rd.live && (rd.key == key_reg);
    assign chain_end  = (rd.link >= NIL) || (step_reg + LINK_W'(1) == NIL);
    assign walk_miss  = ((state_reg == S_HEAD) && head_empty) ||
                        ((state_reg == S_SLOT) && !slot_hit && chain_end);
    assign tail_v     = (state_reg == S_HEAD) ? NIL : LINK_W'(cur_reg);

    // Sequencer next-state logic
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        bkt_next       = bkt_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        tail_next      = tail_reg;
        step_next      = step_reg;
        hit_link_next  = hit_link_reg;
        free_head_next = free_head_reg;
        count_next     = count_reg;
        mix_start      = 1'b0;
        head_raddr     = mix_bucket;
        slot_raddr     = cur_reg;
        wr             = '0;
        wr.key_wdata   = key_reg;
        fin            = 1'b0;
        fin_status     = ST_NOTFOUND;
        fin_slot       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd_t'(command);
                    key_next   = key;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (mix_done)
                begin
                    bkt_next  = mix_bucket;
                    prev_next = NIL;
                    if ((cmd_reg == CMD_INSERT) && full)
                    begin
                        fin        = 1'b1;
                        fin_status = ST_FULL;
                    end
                    else
                    begin
                        state_next = S_HEAD;
                    end
                end
            end
            S_HEAD:
            begin
                if (!head_empty)
                begin
                    slot_raddr = rd.head[SLOT_W-1:0];
                    cur_next   = rd.head[SLOT_W-1:0];
                    step_next  = '0;
                    state_next = S_SLOT;
                end
            end
            S_SLOT:
            begin
                if (slot_hit)
                begin
                    case (cmd_reg) inside
                        CMD_FIND, CMD_FIND_OR_INSERT:
                        begin
                            fin        = 1'b1;
                            fin_status = ST_FOUND;
                            fin_slot   = cur_reg;
                        end
                        CMD_INSERT:
                        begin
                            fin        = 1'b1;
                            fin_status = ST_PRESENT;
                        end
                        default:
                        begin
                            hit_link_next = rd.link;
                            state_next    = S_ERASE_UNLINK;
                        end
                    endcase
                end
                else if (!chain_end)
                begin
                    slot_raddr = rd.link[SLOT_W-1:0];
                    cur_next   = rd.link[SLOT_W-1:0];
                    prev_next  = LINK_W'(cur_reg);
                    step_next  = step_reg + LINK_W'(1);
                end
            end
            S_ALLOC_WR:
            begin
                // Pop the free list and link the new slot at the chain tail
                free_head_next = rd.link;
                if (tail_reg < NIL)
                begin
                    wr.slot_waddr = tail_reg[SLOT_W-1:0];
                    wr.link_we    = 1'b1;
                    wr.link_wdata = LINK_W'(cur_reg);
                end
                else
                begin
                    wr.head_we    = 1'b1;
                    wr.head_waddr = bkt_reg;
                    wr.head_wdata = LINK_W'(cur_reg);
                end
                state_next = S_ALLOC_FIN;
            end
            S_ALLOC_FIN:
            begin
                wr.slot_waddr = cur_reg;
                wr.link_we    = 1'b1;
                wr.link_wdata = NIL;
                wr.key_we     = 1'b1;
                wr.live_we    = 1'b1;
                wr.live_wdata = 1'b1;
                count_next    = count_reg + LINK_W'(1);
                fin           = 1'b1;
                fin_status    = ST_INSERTED;
                fin_slot      = cur_reg;
            end
            S_ERASE_UNLINK:
            begin
                if (prev_reg < NIL)
                begin
                    wr.slot_waddr = prev_reg[SLOT_W-1:0];
                    wr.link_we    = 1'b1;
                    wr.link_wdata = hit_link_reg;
                end
                else
                begin
                    wr.head_we    = 1'b1;
                    wr.head_waddr = bkt_reg;
                    wr.head_wdata = hit_link_reg;
                end
                state_next = S_ERASE_FREE;
            end
            S_ERASE_FREE:
            begin
                // Push the slot onto the free list head
                wr.slot_waddr  = cur_reg;
                wr.link_we     = 1'b1;
                wr.link_wdata  = free_head_reg;
                wr.live_we     = 1'b1;
                wr.live_wdata  = 1'b0;
                free_head_next = LINK_W'(cur_reg);
                if (count_reg != '0)
                begin
                    count_next = count_reg - LINK_W'(1);
                end
                fin        = 1'b1;
                fin_status = ST_ERASED;
                fin_slot   = cur_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // End of a walk without a match
        if (walk_miss)
        begin
            case (cmd_reg) inside
                CMD_FIND, CMD_ERASE:
                begin
                    fin        = 1'b1;
                    fin_status = ST_NOTFOUND;
                end
                default:
                begin
                    if (full)
                    begin
                        fin        = 1'b1;
                        fin_status = ST_FULL;
                    end
                    else
                    begin
                        tail_next  = tail_v;
                        slot_raddr = free_head_reg[SLOT_W-1:0];
                        cur_next   = free_head_reg[SLOT_W-1:0];
                        state_next = S_ALLOC_WR;
                    end
                end
            endcase
        end

        mix_start = (state_reg == S_IDLE) && start;

        // Drive the result beat
        done_next   = fin;
        status_next = status_reg;
        slot_next   = slot_reg;
        occ_next    = occ_reg;
        if (fin)
        begin
            state_next  = S_IDLE;
            status_next = fin_status;
            slot_next   = fin_slot;
            occ_next    = count_next;
        end
    end

    // State, table bookkeeping and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
        end
    end

    // Working registers and result payload
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        bkt_reg      <= bkt_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        tail_reg     <= tail_next;
        step_reg     <= step_next;
        hit_link_reg <= hit_link_next;
        status_reg   <= status_next;
        slot_reg     <= slot_next;
        occ_reg      <= occ_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign slot_index = slot_reg;
    assign occupancy  = occ_reg;

endmodule

FILE: rtl/core/chse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chse_checker
// Port-level checks on the hash set engine's command and result beats.
// ----------------------------------------------------------------------------
module chse_checker
    import chse_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic [1:0]        command,
    input logic [KEY_W-1:0]  key,
    input logic              busy,
    input logic              done,
    input logic [2:0]        status,
    input logic [SLOT_W-1:0] slot_index,
    input logic [LINK_W-1:0] occupancy
);

    // An accepted command beat makes the engine busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // Busy drops only with a result beat
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // A result beat arrives with the engine ready again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while still busy");

    // Results without a slot carry slot zero
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_NOTFOUND || status == ST_PRESENT ||
                  status == ST_FULL)) |-> (slot_index == '0))
        else $error("nonzero slot on a slotless result");

    // Occupancy never exceeds the capacity
    a_occ_cap: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (occupancy <= NIL))
        else $error("occupancy above capacity");

endmodule

bind chained_hash_set_engine_unit chse_checker u_chse_checker (.*);
